### rtl/core/assert_macros.svh
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define SAS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define SAS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/sas_pkg.sv
package sas_pkg;

  localparam int ADDR_NIBBLES_DEF = 16;
  localparam int ADDR_W           = 64;

  localparam logic       OP_START = 1'b0;
  localparam logic       OP_RESP  = 1'b1;

  localparam logic [1:0] ST_SINGLE    = 2'd0;
  localparam logic [1:0] ST_COLLISION = 2'd1;
  localparam logic [1:0] ST_NOTHING   = 2'd2;
  localparam logic [1:0] ST_ERROR     = 2'd3;

  localparam logic [3:0] WILD_NIBBLE = 4'hF;
  localparam logic [3:0] LAST_DIGIT  = 4'd9;

  typedef enum logic [1:0] {
    KIND_PROBE = 2'd0,
    KIND_FOUND = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_FAIL  = 2'd3
  } sas_kind_t;

  // one result request from the sequencer to the output register
  typedef struct packed {
    logic              req;
    sas_kind_t         kind;
    logic [ADDR_W-1:0] value;
    logic              last;
  } sas_emit_t;

endpackage

### rtl/core/sas_nib_unit.sv
module sas_nib_unit import sas_pkg::*; #(
  parameter int ADDRESS_NIBBLES = ADDR_NIBBLES_DEF,
  localparam int MW = 4 * ADDRESS_NIBBLES,
  localparam int PW = $clog2(ADDRESS_NIBBLES)
) (
  input  logic [MW-1:0] probe_i,
  input  logic [MW-1:0] base_i,
  input  logic [PW-1:0] pos_i,
  input  logic [3:0]    wr_nib_i,
  output logic [3:0]    cur_nib_o,
  output logic [3:0]    base_nib_o,
  output logic          wild_o,
  output logic [MW-1:0] upd_mask_o
);

  // position 0 is the most significant nibble
  always_comb begin
    cur_nib_o  = '0;
    base_nib_o = '0;
    upd_mask_o = probe_i;
    for (int i = 0; i < ADDRESS_NIBBLES; i++) begin
      if (pos_i == PW'(i)) begin
        cur_nib_o  = probe_i[4*(ADDRESS_NIBBLES-1-i) +: 4];
        base_nib_o = base_i[4*(ADDRESS_NIBBLES-1-i) +: 4];
        upd_mask_o[4*(ADDRESS_NIBBLES-1-i) +: 4] = wr_nib_i;
      end
    end
  end

  assign wild_o = (base_nib_o == WILD_NIBBLE);

endmodule

### rtl/core/sas_seq.sv
module sas_seq import sas_pkg::*; #(
  parameter int ADDRESS_NIBBLES = ADDR_NIBBLES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ADDR_W-1:0] cfg_mask,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_opcode,
  input  logic [1:0]        in_probe_status,
  input  logic [ADDR_W-1:0] in_matched_address,
  output sas_emit_t         emit,
  input  logic              emit_take
);

  localparam int MW = 4 * ADDRESS_NIBBLES;
  localparam int PW = $clog2(ADDRESS_NIBBLES);
  localparam logic [PW-1:0] LAST_POS = PW'(ADDRESS_NIBBLES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DESC,
    S_ADV,
    S_BACK,
    S_PROBE,
    S_FOUND,
    S_FAIL,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [MW-1:0]     probe_r, probe_nxt;
  logic [MW-1:0]     base_r, base_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic              scanning_r, scanning_nxt;
  logic              abandon_r, abandon_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;

  logic [3:0]    wr_nib;
  logic [3:0]    cur_nib;
  logic [3:0]    base_nib;
  logic          wild;
  logic [MW-1:0] upd_mask;
  logic          adv_step;
  logic          accept;

  sas_nib_unit #(.ADDRESS_NIBBLES(ADDRESS_NIBBLES)) u_nib (
    .probe_i   (probe_r),
    .base_i    (base_r),
    .pos_i     (pos_r),
    .wr_nib_i  (wr_nib),
    .cur_nib_o (cur_nib),
    .base_nib_o(base_nib),
    .wild_o    (wild),
    .upd_mask_o(upd_mask)
  );

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign adv_step = !abandon_r && wild && (cur_nib < LAST_DIGIT);

  always_comb begin
    case (state_r)
      S_DESC:  wr_nib = 4'd0;
      S_ADV:   wr_nib = adv_step ? cur_nib + 4'd1 : base_nib;
      default: wr_nib = base_nib;
    endcase
  end

  always_comb begin
    emit.req   = 1'b0;
    emit.kind  = KIND_PROBE;
    emit.value = '0;
    emit.last  = 1'b1;
    case (state_r)
      S_PROBE: begin
        emit.req   = 1'b1;
        emit.value = ADDR_W'(probe_r);
      end
      S_FOUND: begin
        emit.req   = 1'b1;
        emit.kind  = KIND_FOUND;
        emit.value = addr_r;
        emit.last  = 1'b0;
      end
      S_FAIL: begin
        emit.req  = 1'b1;
        emit.kind = KIND_FAIL;
      end
      S_DONE: begin
        emit.req  = 1'b1;
        emit.kind = KIND_DONE;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    probe_nxt    = probe_r;
    base_nxt     = base_r;
    pos_nxt      = pos_r;
    scanning_nxt = scanning_r;
    abandon_nxt  = abandon_r;
    addr_nxt     = addr_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_opcode == OP_START) begin
            base_nxt     = cfg_mask[MW-1:0];
            probe_nxt    = cfg_mask[MW-1:0];
            pos_nxt      = '0;
            scanning_nxt = 1'b1;
            state_nxt    = S_DESC;
          end else if (scanning_r) begin
            abandon_nxt = 1'b0;
            case (in_probe_status)
              ST_SINGLE: begin
                addr_nxt  = in_matched_address;
                state_nxt = S_FOUND;
              end
              ST_COLLISION: begin
                if (pos_r != LAST_POS) begin
                  pos_nxt   = pos_r + PW'(1);
                  state_nxt = S_DESC;
                end else begin
                  state_nxt = S_ADV;
                end
              end
              ST_NOTHING: state_nxt = S_ADV;
              default: begin
                if (pos_r == '0) begin
                  scanning_nxt = 1'b0;
                  state_nxt    = S_FAIL;
                end else begin
                  abandon_nxt = 1'b1;
                  state_nxt   = S_ADV;
                end
              end
            endcase
          end
        end
      end
      // skip fixed positions, the last one is probed as is
      S_DESC: begin
        if (pos_r != LAST_POS && !wild) begin
          pos_nxt = pos_r + PW'(1);
        end else begin
          if (wild) probe_nxt = upd_mask;
          state_nxt = S_PROBE;
        end
      end
      S_ADV: begin
        probe_nxt   = upd_mask;
        abandon_nxt = 1'b0;
        if (adv_step) begin
          state_nxt = S_PROBE;
        end else if (pos_r == '0) begin
          scanning_nxt = 1'b0;
          state_nxt    = S_DONE;
        end else begin
          pos_nxt   = pos_r - PW'(1);
          state_nxt = S_BACK;
        end
      end
      // walk up to the nearest enumerating level
      S_BACK: begin
        if (wild) begin
          state_nxt = S_ADV;
        end else if (pos_r == '0) begin
          scanning_nxt = 1'b0;
          state_nxt    = S_DONE;
        end else begin
          pos_nxt = pos_r - PW'(1);
        end
      end
      S_FOUND: if (emit_take) state_nxt = S_ADV;
      S_PROBE, S_FAIL, S_DONE: if (emit_take) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pos_r      <= '0;
      scanning_r <= 1'b0;
      abandon_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pos_r      <= pos_nxt;
      scanning_r <= scanning_nxt;
      abandon_r  <= abandon_nxt;
    end
    probe_r <= probe_nxt;
    base_r  <= base_nxt;
    addr_r  <= addr_nxt;
  end

endmodule

### rtl/core/secondary_address_scan.sv
// start request: the sequencer loads the mask, skips the fixed positions in S_DESC,
//   writes zero into the first enumerating one and holds the probe in S_PROBE until registered
// response request: while backtracking, the sequencer steps up past each fixed position
//   in S_BACK and visits each enumerating position in S_BACK and then S_ADV
// one request at a time; a result may wait in the output register meanwhile
// sync active-low reset: sequencer idle, scan and pending result dropped, cfg_mask_r all ones
module secondary_address_scan import sas_pkg::*; #(
  parameter int ADDRESS_NIBBLES = ADDR_NIBBLES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ADDR_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_opcode,
  input  logic [1:0]        in_probe_status,
  input  logic [ADDR_W-1:0] in_matched_address,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [ADDR_W-1:0] out_address_value,
  output logic              out_last
);

  logic [ADDR_W-1:0] cfg_mask_r;
  logic              out_valid_r;
  sas_kind_t         out_kind_r;
  logic [ADDR_W-1:0] out_value_r;
  logic              out_last_r;
  sas_emit_t         emit;
  logic              emit_take;

  sas_seq #(.ADDRESS_NIBBLES(ADDRESS_NIBBLES)) u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_mask          (cfg_mask_r),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_probe_status   (in_probe_status),
    .in_matched_address(in_matched_address),
    .emit              (emit),
    .emit_take         (emit_take)
  );

  assign cfg_ready = 1'b1;
  assign emit_take = emit.req && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mask_r  <= '1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) cfg_mask_r <= cfg_data;
      if (emit_take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (emit_take) begin
      out_kind_r  <= emit.kind;
      out_value_r <= emit.value;
      out_last_r  <= emit.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_address_value = out_value_r;
  assign out_last          = out_last_r;

endmodule

### rtl/core/sas_checker.sv
`include "assert_macros.svh"

module sas_checker import sas_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_opcode,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        out_kind,
  input logic [ADDR_W-1:0] out_address_value,
  input logic              out_last
);

  `SAS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_address_value), "result dropped or changed while stalled")
  `SAS_ASSERT(a_start_busy, in_valid && in_ready && in_opcode == OP_START |=> !in_ready, "ready right after a start request")
  `SAS_ASSERT(a_end_zero, out_valid && (out_kind == KIND_DONE || out_kind == KIND_FAIL) |-> out_address_value == '0 && out_last, "end result not zero or not last")
  `SAS_ASSERT(a_found_not_last, out_valid && out_kind == KIND_FOUND |-> !out_last, "device found marked last")
  `SAS_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result pending after reset")

endmodule

bind secondary_address_scan sas_checker u_sas_checker (.*);
